/* rtl/core/scba_pkg.sv */
// Shared types and constants for the size-class buffer allocator.
package scba_pkg;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [4:0] SHIFT_RESET    = 5'd6;
   localparam logic [3:0] OVERSIZE_CLASS = 4'd15;

   typedef enum logic [2:0] {
      ST_GRANTED     = 3'd0,
      ST_FULL        = 3'd1,
      ST_OVERSIZE    = 3'd2,
      ST_RELEASED    = 3'd3,
      ST_BAD_RELEASE = 3'd4
   } status_type;

   typedef struct packed {
      logic        command;
      logic [31:0] request_size;
      logic [3:0]  release_class;
      logic [3:0]  release_slot;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  size_class;
      logic [3:0]  slot;
      logic [31:0] buffer_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic grant;
      logic release_en;
   } map_cmd_type;

   typedef struct packed {
      logic any_free;
      logic slot_taken;
   } map_stat_type;

endpackage

/* rtl/core/scba_class_calc.sv */
// Size class and granted buffer size from a request size and the lowest-size shift.
module scba_class_calc
   import scba_pkg::*;
(
   input  logic [31:0] request_size,
   input  logic [4:0]  lowest_size_shift,
   output logic [5:0]  size_class,
   output logic [31:0] buffer_bytes
);

   logic [5:0] bit_len;
   logic [5:0] shift_ext;
   logic [5:0] exponent;

   // The bit length of the shifted size equals the bit length of the size less the shift.
   always_comb begin
      bit_len = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (request_size[i]) begin
            bit_len = 6'(i + 1);
         end
      end
   end

   assign shift_ext  = {1'b0, lowest_size_shift};
   assign size_class = (bit_len > shift_ext) ? (bit_len - shift_ext) : 6'd0;

   // Shift plus class is the bit length whenever the class is above zero.
   assign exponent     = (size_class == 6'd0) ? shift_ext : bit_len;
   assign buffer_bytes = (exponent >= 6'd32) ? 32'hFFFF_FFFF : (32'd1 << exponent[4:0]);

endmodule

/* rtl/core/scba_slot_map.sv */
// Per-class allocated-flag bitmaps with lowest-free-slot search and update.
module scba_slot_map
   import scba_pkg::*;
#(
   parameter int NUM_CLASSES     = 15,
   parameter int SLOTS_PER_CLASS = 16,
   localparam int CLASS_IDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
   localparam int SLOT_IDX_W     = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  map_cmd_type            cmd,
   input  logic [CLASS_IDX_W-1:0] class_idx,
   input  logic [SLOT_IDX_W-1:0]  release_slot,
   output map_stat_type           stat,
   output logic [SLOT_IDX_W-1:0]  free_slot
);

   logic [SLOTS_PER_CLASS-1:0] map_ff [NUM_CLASSES];
   logic [SLOTS_PER_CLASS-1:0] row;
   logic [SLOTS_PER_CLASS-1:0] free_bits;

   assign row       = map_ff[class_idx];
   assign free_bits = ~row;

   always_comb begin
      free_slot = '0;
      for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_slot = SLOT_IDX_W'(i);
         end
      end
   end

   assign stat.any_free   = |free_bits;
   assign stat.slot_taken = row[release_slot];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            map_ff[c] <= '0;
         end
      end else if (cmd.grant && stat.any_free) begin
         map_ff[class_idx][free_slot] <= 1'b1;
      end else if (cmd.release_en && stat.slot_taken) begin
         map_ff[class_idx][release_slot] <= 1'b0;
      end
   end

endmodule

/* rtl/core/size_class_buffer_allocator_core.sv */
// Top level of the size-class buffer allocator: input register, allocation logic, result register.
//
// Each word started while busy is low (busy is never raised) produces exactly one result word on
// rsp_word once it has passed the input register and the result register, marked by rsp_valid for
// one cycle; a new word may be started on every clock. The class bitmap read, lowest-free-slot
// search and bitmap update all complete between those two registers, with the bitmap written at
// the same clock edge as the result, so back-to-back requests to the same class always see each
// other's grants. All bitmaps clear together at reset; no clearing pass is needed.
module size_class_buffer_allocator_core
   import scba_pkg::*;
#(
   parameter int NUM_CLASSES     = 15,
   parameter int SLOTS_PER_CLASS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [4:0]   csr_write_data
);

   localparam int CLASS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_IDX_W  = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;

   logic         valid_ff;
   req_word_type req_ff;
   logic [4:0]   shift_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;

   logic [5:0]   calc_class;
   logic [31:0]  calc_bytes;
   logic         oversize;
   logic [5:0]   rel_class_ext;
   logic [6:0]   rel_slot_ext;
   logic         release_ok;
   logic [5:0]   free_slot_ext;

   map_cmd_type             map_cmd;
   map_stat_type            map_stat;
   logic [CLASS_IDX_W-1:0]  map_class_idx;
   logic [SLOT_IDX_W-1:0]   map_free_slot;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= SHIFT_RESET;
      end else begin
         valid_ff     <= start && !busy;
         rsp_valid_ff <= valid_ff;
         if (csr_write_enable) begin
            shift_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

   scba_class_calc u_class_calc (
      .request_size      (req_ff.request_size),
      .lowest_size_shift (shift_ff),
      .size_class        (calc_class),
      .buffer_bytes      (calc_bytes)
   );

   assign oversize      = calc_class >= 6'(NUM_CLASSES);
   assign rel_class_ext = {2'b00, req_ff.release_class};
   assign rel_slot_ext  = {3'b000, req_ff.release_slot};
   assign release_ok    = (rel_class_ext < 6'(NUM_CLASSES)) &&
                          (rel_slot_ext < 7'(SLOTS_PER_CLASS));

   assign map_class_idx      = (req_ff.command == CMD_RELEASE) ?
                               rel_class_ext[CLASS_IDX_W-1:0] : calc_class[CLASS_IDX_W-1:0];
   assign map_cmd.grant      = valid_ff && (req_ff.command == CMD_REQUEST) && !oversize;
   assign map_cmd.release_en = valid_ff && (req_ff.command == CMD_RELEASE) && release_ok;

   scba_slot_map #(
      .NUM_CLASSES     (NUM_CLASSES),
      .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
   ) u_slot_map (
      .clock        (clock),
      .reset        (reset),
      .cmd          (map_cmd),
      .class_idx    (map_class_idx),
      .release_slot (rel_slot_ext[SLOT_IDX_W-1:0]),
      .stat         (map_stat),
      .free_slot    (map_free_slot)
   );

   assign free_slot_ext = 6'(map_free_slot);

   always_comb begin
      rsp_in = '{status: ST_BAD_RELEASE, size_class: req_ff.release_class,
                 slot: 4'd0, buffer_bytes: 32'd0};
      if (req_ff.command == CMD_REQUEST) begin
         if (oversize) begin
            rsp_in.status     = ST_OVERSIZE;
            rsp_in.size_class = OVERSIZE_CLASS;
         end else if (!map_stat.any_free) begin
            rsp_in.status     = ST_FULL;
            rsp_in.size_class = calc_class[3:0];
         end else begin
            rsp_in.status       = ST_GRANTED;
            rsp_in.size_class   = calc_class[3:0];
            rsp_in.slot         = free_slot_ext[3:0];
            rsp_in.buffer_bytes = calc_bytes;
         end
      end else if (release_ok && map_stat.slot_taken) begin
         rsp_in.status = ST_RELEASED;
         rsp_in.slot   = req_ff.release_slot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Every accepted word yields exactly one result, after the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !$past(valid_ff) |-> !rsp_valid)
      else $error("result without an accepted word");

   a_grant_has_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_GRANTED) |-> (rsp_word.buffer_bytes != 32'd0))
      else $error("granted buffer reported with zero size");

   a_oversize_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_OVERSIZE) |->
         (rsp_word.size_class == OVERSIZE_CLASS && rsp_word.slot == 4'd0 &&
          rsp_word.buffer_bytes == 32'd0))
      else $error("oversize result carries slot or size");

   a_release_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == ST_RELEASED || rsp_word.status == ST_BAD_RELEASE)) |->
         (rsp_word.buffer_bytes == 32'd0))
      else $error("release result carries a buffer size");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the size-class buffer allocator core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import scba_pkg::*;

   localparam int NUM_CLASSES     = 15;
   localparam int SLOTS_PER_CLASS = 16;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int SETTLE_CYCLES   = 4;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         start            = 1'b0;
   logic         busy;
   req_word_type req_word         = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [4:0]   csr_write_data   = '0;

   // Expected state of the block: one allocated flag per slot, and the size shift.
   logic [SLOTS_PER_CLASS-1:0] class_map [NUM_CLASSES];
   logic [4:0]                 size_shift = SHIFT_RESET;
   rsp_word_type               expected_words [$];
   int                         mismatch_count = 0;
   int                         cycle_count    = 0;
   bit                         sender_quiet   = 1'b0;

   size_class_buffer_allocator_core #(
      .NUM_CLASSES    (NUM_CLASSES),
      .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_word        (rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Works out the result word of one accepted word and updates the expected bitmaps.
   function automatic rsp_word_type allocate_or_release(req_word_type w);
      rsp_word_type      r;
      logic [31:0]       quotient;
      int                cls;
      int                s;
      longint unsigned   bytes;
      r = '0;
      if (w.command == CMD_REQUEST) begin
         quotient = w.request_size >> size_shift;
         cls = 0;
         for (int b = 0; b < 32; b++) begin
            if (quotient[b]) cls = b + 1;
         end
         if (cls >= NUM_CLASSES) begin
            r.status     = ST_OVERSIZE;
            r.size_class = OVERSIZE_CLASS;
         end else if (&class_map[cls]) begin
            r.status     = ST_FULL;
            r.size_class = cls[3:0];
         end else begin
            s = 0;
            while (class_map[cls][s]) s++;
            class_map[cls][s] = 1'b1;
            bytes = 64'd1 << (size_shift + cls);
            r.status       = ST_GRANTED;
            r.size_class   = cls[3:0];
            r.slot         = s[3:0];
            r.buffer_bytes = (bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : bytes[31:0];
         end
      end else begin
         r.size_class = w.release_class;
         if (w.release_class >= NUM_CLASSES || w.release_slot >= SLOTS_PER_CLASS
             || !class_map[w.release_class][w.release_slot]) begin
            r.status = ST_BAD_RELEASE;
         end else begin
            class_map[w.release_class][w.release_slot] = 1'b0;
            r.status = ST_RELEASED;
            r.slot   = w.release_slot;
         end
      end
      return r;
   endfunction

   // The fields a command does not use carry random values, so the block must ignore them.
   function automatic req_word_type request_of(logic [31:0] size);
      req_word_type w;
      w.command       = CMD_REQUEST;
      w.request_size  = size;
      w.release_class = 4'($urandom);
      w.release_slot  = 4'($urandom);
      return w;
   endfunction

   function automatic req_word_type release_of(logic [3:0] cls, logic [3:0] slot);
      req_word_type w;
      w.command       = CMD_RELEASE;
      w.request_size  = $urandom;
      w.release_class = cls;
      w.release_slot  = slot;
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      if (!sender_quiet && $urandom_range(0, 99) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      expected_words.push_back(allocate_or_release(w));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_shift(logic [4:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_shift = value;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: status %0d class %0d slot %0d bytes %h",
                        rsp_word.status, rsp_word.size_class, rsp_word.slot,
                        rsp_word.buffer_bytes);
         end else begin
            want = expected_words.pop_front();
            if (want.status !== rsp_word.status || want.size_class !== rsp_word.size_class
                || want.slot !== rsp_word.slot || want.buffer_bytes !== rsp_word.buffer_bytes)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected status %0d class %0d slot %0d bytes %h, %s",
                           want.status, want.size_class, want.slot, want.buffer_bytes,
                           $sformatf("got status %0d class %0d slot %0d bytes %h",
                                     rsp_word.status, rsp_word.size_class, rsp_word.slot,
                                     rsp_word.buffer_bytes));
            end
         end
      end
   end

   // Reset shift: zero size, class edges, oversize, releases and a class filled to the brim.
   task automatic test_reset_shift_cases();
      send_word(request_of(32'd0));
      send_word(request_of(32'd64));
      send_word(request_of(32'hFFFF_FFFF));
      send_word(request_of(32'h0008_0000));
      send_word(request_of(32'h0010_0000));
      send_word(release_of(OVERSIZE_CLASS, 4'd0));
      send_word(release_of(4'd14, 4'd3));
      send_word(release_of(4'd14, 4'd0));
      send_word(release_of(4'd14, 4'd0));
      repeat (15) send_word(request_of(32'd63));
      send_word(request_of(32'd1));
      send_word(release_of(4'd0, 4'd15));
      send_word(release_of(4'd0, 4'd7));
      send_word(request_of(32'd0));
   endtask

   // Shift zero and the large shifts 24 and 31, where buffer sizes can run past 32 bits and saturate.
   task automatic test_shift_extremes();
      logic [4:0]  shifts [3] = '{5'd0, 5'd24, 5'd31};
      logic [31:0] sizes  [6] = '{32'd0, 32'd1, 32'h0000_2000, 32'h00FF_FFFF,
                                  32'h0100_0000, 32'hFFFF_FFFF};
      foreach (shifts[i]) begin
         write_shift(shifts[i]);
         foreach (sizes[j]) send_word(request_of(sizes[j]));
      end
   endtask

   // Mostly requests aimed at a chosen class and releases of granted slots, plus noise.
   task automatic test_random_traffic(logic [4:0] shift, int count, bit quiet);
      int              pick;
      int              target;
      int              c;
      int              s;
      bit              found;
      longint unsigned quotient;
      longint unsigned size;
      write_shift(shift);
      sender_quiet = quiet;
      for (int n = 0; n < count; n++) begin
         if (n > 0 && n % 150 == 0) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            size = 64'd0;
            if ($urandom_range(0, 9) != 0) begin
               target   = $urandom_range(0, NUM_CLASSES);
               quotient = 64'd0;
               if (target > 0)
                  quotient = (64'd1 << (target - 1))
                           | (64'($urandom) & ((64'd1 << (target - 1)) - 1));
               size = (quotient << size_shift) | (64'($urandom) & ((64'd1 << size_shift) - 1));
            end
            if (size > 64'hFFFF_FFFF || size == 64'd0 && $urandom_range(0, 1) == 1)
               size = 64'($urandom);
            send_word(request_of(size[31:0]));
         end else begin
            found = 1'b0;
            if (pick < 88) begin
               c = $urandom_range(0, NUM_CLASSES - 1);
               s = $urandom_range(0, SLOTS_PER_CLASS - 1);
               for (int i = 0; i < NUM_CLASSES * SLOTS_PER_CLASS && !found; i++) begin
                  if (class_map[c][s]) begin
                     found = 1'b1;
                  end else begin
                     s = (s + 1) % SLOTS_PER_CLASS;
                     if (s == 0) c = (c + 1) % NUM_CLASSES;
                  end
               end
            end
            if (!found) begin
               c = $urandom_range(0, 15);
               s = $urandom_range(0, 15);
            end
            send_word(release_of(c[3:0], s[3:0]));
         end
      end
      sender_quiet = 1'b0;
   endtask

   initial begin
      foreach (class_map[i]) class_map[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_shift_cases();
      test_shift_extremes();
      test_random_traffic(SHIFT_RESET, 475, 1'b0);
      test_random_traffic(5'd0, 475, 1'b1);
      test_random_traffic(5'd24, 475, 1'b0);
      test_random_traffic(5'($urandom_range(1, 23)), 475, 1'b0);
      drain_results();
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
